### rtl/tem_pkg.sv
// Shared types, widths and codes for the text extent measuring block.
// Used by every module of the block and by its checker; depends on nothing.
package tem_pkg;

    localparam int GLYPH_COUNT_DEF = 1024;

    localparam int SLOT_W        = 10;
    localparam int STEP_W        = 12;
    localparam int LINE_HEIGHT_W = 12;
    localparam int BYTE_W        = 8;
    localparam int DIM_W         = 16;
    localparam int CODE_W        = 21;
    localparam int OP_IDX_W      = 16;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_INDEX_W   = 1;

    localparam int QUEUE_DEPTH    = 4;
    localparam int FALLBACK_GLYPH = 63;

    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    localparam logic [DIM_W-1:0] DIM_MAX = '1;

    // Item function codes.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TEXT  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_HEIGHT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FONT_LOADED = 1'd1;

    typedef enum logic [1:0] {
        OP_GLYPH   = 2'd0,
        OP_WRITE   = 2'd1,
        OP_NEWLINE = 2'd2,
        OP_FINISH  = 2'd3
    } op_kind_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] glyph_slot;
        logic [STEP_W-1:0] glyph_step;
        logic              glyph_present;
        logic [BYTE_W-1:0] text_byte;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0] box_width;
        logic [DIM_W-1:0] box_height;
        logic             saturated;
    } result_t;

    typedef struct packed {
        logic              present;
        logic [STEP_W-1:0] step;
    } glyph_entry_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [OP_IDX_W-1:0] idx;
        glyph_entry_t        entry;
    } op_t;

    typedef struct packed {
        logic [LINE_HEIGHT_W-1:0] line_height;
        logic                     font_loaded;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/text_extent_measure_core.sv
// Top level of the text extent measuring block: configuration registers and the
// front end, operation queue and back end. Depends on tem_pkg and the tem_* modules.
//
// Usage. The item channel (item_valid, item_stall, item) carries glyph table writes,
// UTF-8 text bytes and end-of-string markers. Each end of string yields one transfer
// on the result channel (result_valid, result_stall, result) with the widest line,
// the total height and a saturation flag; no other item yields a result.
// Throughput is one item per cycle while item_stall is low. An item that breaks a
// UTF-8 sequence, or an end of string that finds an unfinished sequence, holds
// item_stall high while each pending byte is replayed as glyph 0.
// An end of string reaches result_valid through the front end hold register, the
// operation queue and the back end stage, behind any replayed bytes.
// After reset the glyph table is cleared one entry per cycle,
// with item_stall held high; configuration writes are taken at any time.
// While result_stall holds a result, the back end keeps the next end of string, the
// queue fills and item_stall rises; nothing is dropped.
module text_extent_measure_core #(
    parameter int GLYPH_COUNT = tem_pkg::GLYPH_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  tem_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output tem_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [tem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tem_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tem_pkg::*;

    cfg_t          cfg_reg;
    op_t           push_op;
    op_t           head_op;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    logic          clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_HEIGHT: cfg_reg.line_height <= cfg_data[LINE_HEIGHT_W-1:0];
                CFG_FONT_LOADED: cfg_reg.font_loaded <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tem_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .clearing   (clearing),
        .q_status   (q_status),
        .push       (push),
        .push_op    (push_op)
    );

    tem_op_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .q_status (q_status)
    );

    tem_back #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_op      (head_op),
        .q_status     (q_status),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### rtl/tem_front.sv
// Front end: accepts items, decodes UTF-8 and turns each item into queue operations.
// Depends on tem_pkg; feeds tem_op_queue.
module tem_front #(
    parameter int GLYPH_COUNT = tem_pkg::GLYPH_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  tem_pkg::item_t         item,
    input  logic                   clearing,
    input  tem_pkg::queue_status_t q_status,
    output logic                   push,
    output tem_pkg::op_t           push_op
);
    import tem_pkg::*;

    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(GLYPH_COUNT - 1);

    logic [3*BYTE_W-1:0] pend_bytes_reg;
    logic [3*BYTE_W-1:0] pend_bytes_next;
    logic [1:0]          pend_count_reg;
    logic [1:0]          pend_count_next;
    logic [1:0]          flush_left_reg;
    logic [1:0]          flush_left_next;
    logic                hold_valid_reg;
    logic                hold_valid_next;
    op_t                 hold_op_reg;
    op_t                 hold_op_next;

    logic                accept;
    logic                push_valid;
    logic                take_fresh;
    logic [BYTE_W-1:0]   lead;
    logic [BYTE_W-1:0]   byte1;
    logic [BYTE_W-1:0]   byte2;
    logic [BYTE_W-1:0]   cur;
    logic [1:0]          need;
    logic [CODE_W-1:0]   code;
    op_t                 zero_glyph;

    function automatic logic [1:0] extra_bytes(input logic [BYTE_W-1:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b >= 8'hC2 && b <= 8'hDF)
        begin
            n = 2'd1;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            n = 2'd2;
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic cont_ok(input logic [BYTE_W-1:0] ld, input logic [1:0] pos,
                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        // The second byte after a few leads has a narrower range.
        if (pos == 2'd1)
        begin
            if (ld == 8'hE0)
            begin
                lo = 8'hA0;
            end
            else if (ld == 8'hED)
            begin
                hi = 8'h9F;
            end
            else if (ld == 8'hF0)
            begin
                lo = 8'h90;
            end
            else if (ld == 8'hF4)
            begin
                hi = 8'h8F;
            end
        end
        return (b >= lo) && (b <= hi);
    endfunction

    function automatic op_t glyph_op(input logic [CODE_W-1:0] c);
        op_t o;
        o.kind  = OP_GLYPH;
        o.idx   = OP_IDX_W'((c > CODE_MAX) ? CODE_MAX : c);
        o.entry = '0;
        return o;
    endfunction

    assign zero_glyph = glyph_op('0);
    assign lead       = pend_bytes_reg[BYTE_W-1:0];
    assign byte1      = pend_bytes_reg[2*BYTE_W-1:BYTE_W];
    assign byte2      = pend_bytes_reg[3*BYTE_W-1:2*BYTE_W];
    assign cur        = item.text_byte;
    assign need       = extra_bytes(lead);

    always_comb
    begin
        case (need)
            2'd1:    code = CODE_W'({lead[4:0], cur[5:0]});
            2'd2:    code = CODE_W'({lead[3:0], byte1[5:0], cur[5:0]});
            default: code = {lead[2:0], byte1[5:0], byte2[5:0], cur[5:0]};
        endcase
    end

    always_comb
    begin
        pend_bytes_next = pend_bytes_reg;
        pend_count_next = pend_count_reg;
        flush_left_next = '0;
        hold_valid_next = 1'b0;
        hold_op_next    = zero_glyph;
        take_fresh      = 1'b0;

        unique case (item.func)
            FUNC_WRITE:
            begin
                hold_valid_next       = 32'(item.glyph_slot) < 32'(GLYPH_COUNT);
                hold_op_next.kind     = OP_WRITE;
                hold_op_next.idx      = OP_IDX_W'(item.glyph_slot);
                hold_op_next.entry    = '{present: item.glyph_present, step: item.glyph_step};
            end
            FUNC_TEXT:
            begin
                if (pend_count_reg == 2'd0)
                begin
                    take_fresh = 1'b1;
                end
                else if (!cont_ok(lead, pend_count_reg, cur))
                begin
                    // Broken sequence: every pending byte counts as glyph 0, then the
                    // offending byte is decoded afresh.
                    flush_left_next = pend_count_reg;
                    pend_count_next = 2'd0;
                    take_fresh      = 1'b1;
                end
                else if (pend_count_reg == need)
                begin
                    hold_valid_next = 1'b1;
                    hold_op_next    = glyph_op(code);
                    pend_count_next = 2'd0;
                end
                else
                begin
                    if (pend_count_reg == 2'd1)
                    begin
                        pend_bytes_next[2*BYTE_W-1:BYTE_W] = cur;
                    end
                    else
                    begin
                        pend_bytes_next[3*BYTE_W-1:2*BYTE_W] = cur;
                    end
                    pend_count_next = pend_count_reg + 2'd1;
                end
            end
            FUNC_END:
            begin
                flush_left_next   = pend_count_reg;
                pend_count_next   = 2'd0;
                hold_valid_next   = 1'b1;
                hold_op_next.kind = OP_FINISH;
            end
            default:
            begin
                hold_valid_next = 1'b0;
            end
        endcase

        if (take_fresh)
        begin
            if (cur == BYTE_LF)
            begin
                hold_valid_next   = 1'b1;
                hold_op_next.kind = OP_NEWLINE;
            end
            else if (cur == BYTE_CR)
            begin
                hold_valid_next = 1'b0;
            end
            else if (cur < 8'h80)
            begin
                hold_valid_next = 1'b1;
                hold_op_next    = glyph_op(CODE_W'(cur));
            end
            else if (extra_bytes(cur) != 2'd0)
            begin
                pend_bytes_next = 24'(cur);
                pend_count_next = 2'd1;
            end
            else
            begin
                hold_valid_next = 1'b1;
                hold_op_next    = zero_glyph;
            end
        end
    end

    assign push_valid = (flush_left_reg != 2'd0) || hold_valid_reg;
    assign push       = push_valid && !q_status.full;
    assign push_op    = (flush_left_reg != 2'd0) ? zero_glyph : hold_op_reg;
    assign item_stall = clearing || (flush_left_reg != 2'd0) ||
                        (hold_valid_reg && q_status.full);
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_count_reg <= '0;
            flush_left_reg <= '0;
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_count_reg <= pend_count_next;
            flush_left_reg <= flush_left_next;
            hold_valid_reg <= hold_valid_next;
        end
        else if (push)
        begin
            if (flush_left_reg != 2'd0)
            begin
                flush_left_reg <= flush_left_reg - 2'd1;
            end
            else
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_bytes_reg <= pend_bytes_next;
            hold_op_reg    <= hold_op_next;
        end
    end

endmodule

### rtl/tem_op_queue.sv
// Short operation queue between the decoding front end and the measuring back end.
// Depends on tem_pkg for the operation type and the queue depth.
module tem_op_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tem_pkg::op_t           push_op,
    input  logic                   pop,
    output tem_pkg::op_t           head_op,
    output tem_pkg::queue_status_t q_status
);
    import tem_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head_op        = entries[rd_ptr_reg];
    assign q_status.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_status.empty = count_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### rtl/tem_back.sv
// Back end: glyph table memory, line width and height accumulation, result register.
// Depends on tem_pkg; drains tem_op_queue.
module tem_back #(
    parameter int GLYPH_COUNT = tem_pkg::GLYPH_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tem_pkg::cfg_t          cfg,
    input  tem_pkg::op_t           head_op,
    input  tem_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   clearing,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tem_pkg::result_t       result
);
    import tem_pkg::*;

    localparam int IDX_W  = $clog2(GLYPH_COUNT);
    localparam int PROD_W = LINE_HEIGHT_W + DIM_W;
    localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(GLYPH_COUNT - 1);
    localparam logic [IDX_W-1:0] FALLBACK_IDX = IDX_W'(FALLBACK_GLYPH);

    glyph_entry_t      glyph_mem [GLYPH_COUNT];
    glyph_entry_t      rdata_reg;
    glyph_entry_t      fallback_reg;
    logic              clearing_reg;
    logic [IDX_W-1:0]  clear_idx_reg;

    logic              s1_valid_reg;
    op_kind_t          s1_kind_reg;

    logic [DIM_W-1:0]  line_width_reg;
    logic [DIM_W-1:0]  line_width_next;
    logic [DIM_W-1:0]  widest_reg;
    logic [DIM_W-1:0]  widest_next;
    logic [DIM_W-1:0]  line_count_reg;
    logic [DIM_W-1:0]  line_count_next;
    logic              overflow_reg;
    logic              overflow_next;

    logic              result_valid_reg;
    result_t           result_reg;
    result_t           finish_value;

    logic [IDX_W-1:0]  head_idx;
    logic              out_free;
    logic              s1_consume;
    logic              s1_free;
    glyph_entry_t      used_entry;
    logic [DIM_W:0]    sum;
    logic [DIM_W-1:0]  sum_sat;
    logic [PROD_W-1:0] prod;
    logic              height_sat;

    assign head_idx   = head_op.idx[IDX_W-1:0];
    assign out_free   = !result_valid_reg || !result_stall;
    // Only an end of string can wait, and only for the result register.
    assign s1_consume = s1_valid_reg && ((s1_kind_reg != OP_FINISH) || out_free);
    assign s1_free    = !s1_valid_reg || s1_consume;
    assign pop        = !q_status.empty && s1_free && !clearing_reg;
    assign clearing   = clearing_reg;

    // Clearing pass after reset, one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_idx_reg <= clear_idx_reg + 1'b1;
            if (clear_idx_reg == LAST_IDX)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            glyph_mem[clear_idx_reg] <= '0;
        end
        else if (pop && head_op.kind == OP_WRITE)
        begin
            glyph_mem[head_idx] <= head_op.entry;
        end
        if (pop)
        begin
            rdata_reg <= glyph_mem[head_idx];
        end
    end

    // Copy of the fallback entry so a missing glyph needs only one table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= '0;
        end
        else if (pop && head_op.kind == OP_WRITE && head_idx == FALLBACK_IDX)
        begin
            fallback_reg <= head_op.entry;
        end
    end

    assign used_entry = rdata_reg.present ? rdata_reg : fallback_reg;
    assign sum        = {1'b0, line_width_reg} + (DIM_W + 1)'(used_entry.step);
    assign sum_sat    = sum[DIM_W] ? DIM_MAX : sum[DIM_W-1:0];
    assign prod       = PROD_W'(cfg.line_height) * PROD_W'(line_count_reg);
    assign height_sat = |prod[PROD_W-1:DIM_W];

    always_comb
    begin
        finish_value.box_width  = widest_reg;
        finish_value.box_height = height_sat ? DIM_MAX : prod[DIM_W-1:0];
        finish_value.saturated  = overflow_reg || height_sat;
        if (!cfg.font_loaded)
        begin
            finish_value = '0;
        end
    end

    always_comb
    begin
        line_width_next = line_width_reg;
        widest_next     = widest_reg;
        line_count_next = line_count_reg;
        overflow_next   = overflow_reg;
        unique case (s1_kind_reg)
            OP_GLYPH:
            begin
                line_width_next = sum_sat;
                overflow_next   = overflow_reg || sum[DIM_W];
                if (sum_sat > widest_reg)
                begin
                    widest_next = sum_sat;
                end
            end
            OP_NEWLINE:
            begin
                line_width_next = '0;
                if (line_count_reg != DIM_MAX)
                begin
                    line_count_next = line_count_reg + 1'b1;
                end
            end
            OP_FINISH:
            begin
                line_width_next = '0;
                widest_next     = '0;
                line_count_next = DIM_W'(1);
                overflow_next   = 1'b0;
            end
            default:
            begin
                line_width_next = line_width_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s1_kind_reg      <= OP_GLYPH;
            line_width_reg   <= '0;
            widest_reg       <= '0;
            line_count_reg   <= DIM_W'(1);
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= pop;
                s1_kind_reg  <= head_op.kind;
            end
            if (s1_consume)
            begin
                line_width_reg <= line_width_next;
                widest_reg     <= widest_next;
                line_count_reg <= line_count_next;
                overflow_reg   <= overflow_next;
            end
            if (s1_consume && s1_kind_reg == OP_FINISH)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_consume && s1_kind_reg == OP_FINISH)
        begin
            result_reg <= finish_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/tem_checker.sv
// Port-level checker for text_extent_measure_core, attached by the bind below.
// Depends on tem_pkg; tracks the configuration writes it sees on the ports.
module tem_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_stall,
    input logic                             result_valid,
    input logic                             result_stall,
    input tem_pkg::result_t                 result,
    input logic                             cfg_we,
    input logic [tem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [tem_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tem_pkg::*;

    logic [LINE_HEIGHT_W-1:0] line_height_reg;
    logic                     font_loaded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_height_reg <= '0;
            font_loaded_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LINE_HEIGHT)
            begin
                line_height_reg <= cfg_data[LINE_HEIGHT_W-1:0];
            end
            if (cfg_index == CFG_FONT_LOADED)
            begin
                font_loaded_reg <= cfg_data[0];
            end
        end
    end

    // A stalled result transfer keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Without a font the box is empty.
    a_no_font_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !font_loaded_reg |-> result == '0)
        else $error("nonzero box with no font loaded");

    // Every string has at least one line.
    a_height_min: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && font_loaded_reg |-> result.box_height >= DIM_W'(line_height_reg))
        else $error("box height below one line");

    // The edge that sees reset low has cleared the result register by the next edge.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result offered during reset");

    // The block stalls input right after reset while the glyph table is cleared.
    a_item_blocked: assert property (@(posedge clk)
        !rst_n ##1 rst_n |-> item_stall)
        else $error("item accepted during table clearing");

endmodule

bind text_extent_measure_core tem_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

### test/text_box_checker.sv
// Checker for text_extent_measure_core: watches the item, result and configuration
// ports, predicts the box for every end of string and compares each result transfer.
// Depends on tem_pkg only.
module text_box_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  tem_pkg::item_t                  item,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  tem_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [tem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tem_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              boxes_owed,
    output int                              boxes_seen
);
    import tem_pkg::*;

    glyph_entry_t             glyphs [GLYPH_COUNT_DEF];
    logic [31:0]              pend_bytes;
    logic [2:0]               pend_cnt;
    logic [DIM_W-1:0]         run_width;
    logic [DIM_W-1:0]         widest;
    logic [DIM_W-1:0]         lines;
    logic                     clipped;
    logic [LINE_HEIGHT_W-1:0] row_height;
    logic                     font_on;
    result_t                  boxes_due [$];
    result_t                  want;

    function automatic void clear_string();
        pend_bytes = '0;
        pend_cnt   = '0;
        run_width  = '0;
        widest     = '0;
        lines      = DIM_W'(1);
        clipped    = 1'b0;
    endfunction

    // Adds the advance of one decoded code to the current line.
    function automatic void advance_by(input logic [CODE_W-1:0] code);
        logic [SLOT_W-1:0] idx;
        glyph_entry_t      e;
        logic [DIM_W:0]    sum;
        idx = (code > GLYPH_COUNT_DEF - 1) ? SLOT_W'(GLYPH_COUNT_DEF - 1) : code[SLOT_W-1:0];
        e = glyphs[idx];
        // A missing fallback glyph still lends its stored advance.
        if (!e.present)
            e = glyphs[FALLBACK_GLYPH];
        sum = {1'b0, run_width} + (DIM_W + 1)'(e.step);
        if (sum > {1'b0, DIM_MAX})
        begin
            sum     = {1'b0, DIM_MAX};
            clipped = 1'b1;
        end
        run_width = sum[DIM_W-1:0];
        if (run_width > widest)
            widest = run_width;
    endfunction

    function automatic logic [1:0] trail_count(input logic [7:0] lead);
        if (lead >= 8'hC2 && lead <= 8'hDF)
            return 2'd1;
        if (lead >= 8'hE0 && lead <= 8'hEF)
            return 2'd2;
        if (lead >= 8'hF0 && lead <= 8'hF4)
            return 2'd3;
        return 2'd0;
    endfunction

    function automatic logic cont_in_range(input logic [7:0] lead, input logic [2:0] pos,
                                           input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 3'd1)
        begin
            case (lead)
                8'hE0: lo = 8'hA0;
                8'hED: hi = 8'h9F;
                8'hF0: lo = 8'h90;
                8'hF4: hi = 8'h8F;
                default: ;
            endcase
        end
        return b >= lo && b <= hi;
    endfunction

    function automatic void fresh_byte(input logic [7:0] b);
        if (b == BYTE_LF)
        begin
            run_width = '0;
            if (lines != DIM_MAX)
                lines = lines + 1'b1;
        end
        else if (b != BYTE_CR)
        begin
            if (b < 8'h80)
                advance_by(CODE_W'(b));
            else if (trail_count(b) != 2'd0)
            begin
                pend_bytes = {24'd0, b};
                pend_cnt   = 3'd1;
            end
            else
                advance_by('0);
        end
    endfunction

    // The lead of a broken sequence counts as glyph 0 and the bytes held after it
    // are taken again as fresh bytes.
    function automatic void replay_pending();
        logic [31:0] held;
        logic [2:0]  n;
        held       = pend_bytes;
        n          = pend_cnt;
        pend_bytes = '0;
        pend_cnt   = '0;
        advance_by('0);
        for (int i = 1; i < n && i < 4; i++)
            fresh_byte(held[8*i +: 8]);
    endfunction

    function automatic void text_byte_in(input logic [7:0] b);
        logic [7:0]        lead;
        logic [1:0]        need;
        logic [CODE_W-1:0] cp;
        if (pend_cnt == 3'd0 || pend_cnt > 3'd3)
        begin
            pend_cnt = '0;
            fresh_byte(b);
            return;
        end
        lead = pend_bytes[7:0];
        need = trail_count(lead);
        if (!cont_in_range(lead, pend_cnt, b))
        begin
            replay_pending();
            fresh_byte(b);
            return;
        end
        pend_bytes[8*pend_cnt +: 8] = b;
        pend_cnt = pend_cnt + 1'b1;
        if (pend_cnt < need + 1)
            return;
        case (need)
            2'd1:    cp = CODE_W'({lead[4:0], pend_bytes[13:8]});
            2'd2:    cp = CODE_W'({lead[3:0], pend_bytes[13:8], pend_bytes[21:16]});
            default: cp = {lead[2:0], pend_bytes[13:8], pend_bytes[21:16], pend_bytes[29:24]};
        endcase
        pend_bytes = '0;
        pend_cnt   = '0;
        advance_by(cp);
    endfunction

    function automatic result_t close_box();
        result_t                          box;
        logic [DIM_W+LINE_HEIGHT_W-1:0]   tall;
        if (pend_cnt != 3'd0)
            replay_pending();
        tall = row_height * lines;
        box.box_width = widest;
        box.saturated = clipped;
        if (tall > DIM_MAX)
        begin
            box.box_height = DIM_MAX;
            box.saturated  = 1'b1;
        end
        else
            box.box_height = tall[DIM_W-1:0];
        if (!font_on)
            box = '0;
        clear_string();
        return box;
    endfunction

    function automatic void match_field(input string name, input logic [DIM_W-1:0] want_v,
                                        input logic [DIM_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (glyphs[i])
                glyphs[i] = '0;
            row_height = '0;
            font_on    = 1'b0;
            clear_string();
            boxes_due.delete();
            mismatches = 0;
            boxes_owed = 0;
            boxes_seen = 0;
        end
        else
        begin
            // Results are handled first so that a box predicted in this cycle
            // cannot hide a result transfer that arrived with nothing waiting.
            if (result_valid && !result_stall)
            begin
                boxes_seen++;
                if (boxes_due.size() == 0)
                begin
                    mismatches++;
                    $error("result transfer with no end of string waiting: width %0d height %0d",
                           result.box_width, result.box_height);
                end
                else
                begin
                    want = boxes_due.pop_front();
                    match_field("box_width", want.box_width, result.box_width);
                    match_field("box_height", want.box_height, result.box_height);
                    match_field("saturated", DIM_W'(want.saturated), DIM_W'(result.saturated));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LINE_HEIGHT: row_height = cfg_data[LINE_HEIGHT_W-1:0];
                    CFG_FONT_LOADED: font_on    = cfg_data[0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                case (item.func)
                    FUNC_WRITE: glyphs[item.glyph_slot] = '{item.glyph_present, item.glyph_step};
                    FUNC_TEXT:  text_byte_in(item.text_byte);
                    FUNC_END:   boxes_due = {boxes_due, close_box()};
                    default: ;
                endcase
            end
            boxes_owed = boxes_due.size();
        end
    end

endmodule

### test/tb_text_extent_measure_core.sv
// Testbench top for text_extent_measure_core: writes glyph tables and settings, sends
// UTF-8 strings with random gaps, stalls the result side and reports the verdict.
// Depends on tem_pkg, text_extent_measure_core and text_box_checker.
module tb_text_extent_measure_core;
    import tem_pkg::*;

    localparam logic [1:0] FUNC_NONE   = 2'd3;
    localparam int         FLOOD_LINES = 20;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid;
    logic                   item_stall;
    item_t                  item;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int boxes_owed;
    int boxes_seen;
    int items_sent;
    int strings_sent;
    bit calm;

    always #4 clk = ~clk;

    text_extent_measure_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    text_box_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .boxes_owed   (boxes_owed),
        .boxes_seen   (boxes_seen)
    );

    initial
    begin
        #5_000_000;
        $display("tb_text_extent_measure_core: done, errors");
        $finish;
    end

    // Result side: a fresh stall length before every result transfer.
    initial
    begin : result_side
        int hold;
        result_stall = 1'b0;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    function automatic item_t noise_item();
        logic [63:0] noise;
        item_t       it;
        noise = {$urandom, $urandom};
        it    = noise[$bits(item_t)-1:0];
        return it;
    endfunction

    // Valid stays high after a transfer until the next call decides on a gap.
    task automatic send(input item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        if (it.func != FUNC_NONE)
            items_sent++;
    endtask

    task automatic put_glyph(input int slot, input int step, input bit present);
        item_t it;
        it               = noise_item();
        it.func          = FUNC_WRITE;
        it.glyph_slot    = slot[SLOT_W-1:0];
        it.glyph_step    = step[STEP_W-1:0];
        it.glyph_present = present;
        send(it);
    endtask

    task automatic put_byte(input int b);
        item_t it;
        it           = noise_item();
        it.func      = FUNC_TEXT;
        it.text_byte = b[BYTE_W-1:0];
        send(it);
    endtask

    task automatic put_end();
        item_t it;
        it      = noise_item();
        it.func = FUNC_END;
        send(it);
        strings_sent++;
    endtask

    task automatic put_junk();
        item_t it;
        it      = noise_item();
        it.func = FUNC_NONE;
        send(it);
    endtask

    // Sends the first keep bytes of the UTF-8 form of a code point.
    task automatic put_code(input int code, input int keep);
        logic [7:0] seq [4];
        int         len;
        if (code < 'h80)
        begin
            seq[0] = code[7:0];
            len    = 1;
        end
        else if (code < 'h800)
        begin
            seq[0] = 8'hC0 | code[10:6];
            seq[1] = 8'h80 | code[5:0];
            len    = 2;
        end
        else if (code < 'h10000)
        begin
            seq[0] = 8'hE0 | code[15:12];
            seq[1] = 8'h80 | code[11:6];
            seq[2] = 8'h80 | code[5:0];
            len    = 3;
        end
        else
        begin
            seq[0] = 8'hF0 | code[20:18];
            seq[1] = 8'h80 | code[17:12];
            seq[2] = 8'h80 | code[11:6];
            seq[3] = 8'h80 | code[5:0];
            len    = 4;
        end
        for (int i = 0; i < len && i < keep; i++)
            put_byte(seq[i]);
    endtask

    function automatic int pick_code(input int len);
        int c;
        case (len)
            2: c = $urandom_range('h80, 'h7FF);
            3:
            begin
                do c = $urandom_range('h800, 'hFFFF); while (c >= 'hD800 && c <= 'hDFFF);
            end
            default: c = $urandom_range('h10000, 'h10FFFF);
        endcase
        return c;
    endfunction

    task automatic load_settings(input int height, input bit loaded);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LINE_HEIGHT;
        cfg_data  <= height[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_FONT_LOADED;
        cfg_data  <= CFG_DATA_W'(loaded);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drains the block: every box delivered, then a margin for trailing work.
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (boxes_owed != 0) @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    // One string of random content, mostly well formed, ended by an end of string.
    task automatic random_string();
        int  pieces;
        int  kind;
        int  len;
        int  tail;
        bit  wide;
        calm   = ($urandom_range(0, 3) == 0);
        wide   = ($urandom_range(0, 9) == 0);
        pieces = wide ? $urandom_range(20, 45) : $urandom_range(0, 14);
        repeat (pieces)
        begin
            kind = wide ? 0 : $urandom_range(0, 19);
            if (kind <= 6)
                put_byte($urandom_range('h20, 'h7E));
            else if (kind == 7)
                put_byte($urandom_range(0, 'h7F));
            else if (kind <= 9)
                put_byte(BYTE_LF);
            else if (kind == 10)
                put_byte(BYTE_CR);
            else if (kind <= 14)
            begin
                len = $urandom_range(2, 4);
                put_code(pick_code(len), len);
            end
            else if (kind <= 16)
            begin
                // Cut a sequence short, then break it or leave it open.
                len = $urandom_range(2, 4);
                put_code(pick_code(len), $urandom_range(1, len - 1));
                tail = $urandom_range(0, 3);
                if (tail == 0)
                    put_byte(BYTE_LF);
                else if (tail == 1)
                    put_byte($urandom_range(0, 'h7F));
                else if (tail == 2)
                    put_byte($urandom_range('hC0, 'hFF));
            end
            else if (kind == 17)
                put_byte($urandom_range(0, 1) ? $urandom_range('h80, 'hC1)
                                              : $urandom_range('hF5, 'hFF));
            else if (kind == 18)
                put_glyph($urandom_range(0, 1023), $urandom_range(0, 4095),
                          $urandom_range(0, 3) != 0);
            else
                put_junk();
        end
        put_end();
    endtask

    task automatic run_phase(input int height, input bit loaded, input int budget);
        int target;
        settle();
        load_settings(height, loaded);
        target = items_sent + budget;
        calm   = 1'b0;
        repeat (24)
            put_glyph(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 127),
                      $urandom_range(0, 4095), $urandom_range(0, 7) != 0);
        put_glyph(FALLBACK_GLYPH, $urandom_range(0, 4095), $urandom_range(0, 1));
        put_glyph(GLYPH_COUNT_DEF - 1, $urandom_range(0, 4095), $urandom_range(0, 1));
        while (items_sent < target)
            random_string();
    endtask

    initial
    begin : stimulus
        logic [7:0] probe [$];
        item_valid   = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        items_sent   = 0;
        strings_sent = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed string: fallback glyph absent, clamped codes, every lead class,
        // range limits after E0/ED/F0/F4, lone bad bytes, a broken sequence whose
        // replay meets a line feed, and a sequence left open at end of string.
        load_settings(16, 1'b1);
        put_glyph(FALLBACK_GLYPH, 7, 1'b0);
        put_glyph("A", 4095, 1'b1);
        put_glyph(GLYPH_COUNT_DEF - 1, 100, 1'b1);
        put_glyph(0, 3, 1'b1);
        probe = '{8'h41, 8'h42, BYTE_LF, BYTE_CR, 8'hC2, 8'hA9, 8'hE0, 8'hA0, 8'h80,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'hE0, 8'h80, 8'hFF,
                  8'hC1, 8'hE2, 8'h82, BYTE_LF, 8'hF0, 8'h90};
        foreach (probe[i])
            put_byte(probe[i]);
        put_junk();
        put_end();

        // A run of empty lines at the tallest line height clips the box height.
        settle();
        load_settings(4095, 1'b1);
        calm = 1'b1;
        repeat (FLOOD_LINES) put_byte(BYTE_LF);
        put_end();

        run_phase(0, 1'b0, 170);
        run_phase(4095, 1'b1, 290);
        run_phase(0, 1'b1, 190);
        repeat (4)
            run_phase($urandom_range(1, 4094), $urandom_range(0, 4) != 0, 220);

        settle();
        $display("covered %0d items in %0d strings under several line heights and font states",
                 items_sent, strings_sent);
        $display("%0d boxes compared, %0d mismatches", boxes_seen, mismatches);
        if (mismatches == 0 && boxes_owed == 0)
            $display("tb_text_extent_measure_core: done, clean");
        else
            $display("tb_text_extent_measure_core: done, errors");
        $finish;
    end

endmodule
